// ===== src/esewh_pkg.sv =====
// Package for the encoder speed estimator with hold.
// Shared widths, constants, register indexes and the divider handshake type.
// No dependencies.
package esewh_pkg;

	// field and register widths
	localparam int CNT_W    = 32;
	localparam int TS_W     = 32;
	localparam int RADIUS_W = 11;
	localparam int CPR_W    = 16;
	localparam int THR_W    = 16;
	localparam int HOLD_W   = 8;
	localparam int MAXSP_W  = 16;
	localparam int SPEED_W  = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// arithmetic widths
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DEN_W  = CPR_W + TS_W;     // counts_per_rev * dt
	localparam int ANUM_W = CNT_W + RADIUS_W - 1; // |dc| * radius, |dc| <= 2^31
	localparam int NUM_W  = ANUM_W + 32;      // times the 31-bit speed constant
	localparam int MAG_W  = 31;               // Q8 speed magnitude
	localparam int DIV_STEPS = MAG_W;
	localparam int STEP_W = 5;

	// 2*pi*1e6*256, rounded
	localparam logic [30:0] SPEED_K = 31'd1608495439;
	// ceil(2^23 / 5): exact quotient for 21-bit dividends
	localparam int DIV5_SHIFT = 23;
	localparam logic [20:0] DIV5_M = 21'd1677722;
	localparam logic [27:0] ROUND_HALF = 28'd320;
	localparam logic [15:0] OUT_MAX = 16'hFFFF;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTS_REV   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_THR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd4;

	// register reset values
	localparam logic [RADIUS_W-1:0] RADIUS_RST = 11'd265;
	localparam logic [CPR_W-1:0]    CPR_RST    = 16'd100;
	localparam logic [THR_W-1:0]    THR_RST    = 16'd10;
	localparam logic [HOLD_W-1:0]   HOLD_RST   = 8'd5;
	localparam logic [MAXSP_W-1:0]  MAXSP_RST  = 16'd10000;

	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] quo;
	} div_rsp_t;

endpackage

// ===== src/esewh_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on esewh_pkg.
module esewh_mul (
	input  logic                          clk,
	input  logic [esewh_pkg::MUL_W-1:0]   a,
	input  logic [esewh_pkg::MUL_W-1:0]   b,
	output logic [esewh_pkg::PROD_W-1:0]  p
);

	logic [esewh_pkg::PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= {{esewh_pkg::MUL_W{1'b0}}, a} * {{esewh_pkg::MUL_W{1'b0}}, b};
	end

	assign p = p_q;

endmodule

// ===== src/esewh_div.sv =====
// Restoring divider, one quotient bit per cycle, for the Q8 speed magnitude.
// Quotient saturates to all ones when it would not fit. Depends on esewh_pkg.
module esewh_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [esewh_pkg::NUM_W-1:0]   num,
	input  logic [esewh_pkg::DEN_W-1:0]   den,
	output esewh_pkg::div_rsp_t           rsp
);

	localparam int HI_W = esewh_pkg::NUM_W - esewh_pkg::MAG_W;

	logic                             busy_q;
	logic                             sat_q;
	logic [esewh_pkg::STEP_W-1:0]     cnt_q;
	logic [esewh_pkg::DEN_W-1:0]      den_q;
	logic [esewh_pkg::DEN_W-1:0]      rem_q;
	logic [esewh_pkg::MAG_W-1:0]      sh_q;
	logic [esewh_pkg::MAG_W-1:0]      quo_q;
	logic [esewh_pkg::DEN_W:0]        trial;
	logic [esewh_pkg::DEN_W:0]        diff;
	logic                             ge;
	logic                             last;
	logic [esewh_pkg::DEN_W-1:0]      rem0;

	// top dividend bits; quotient >= 2^31 exactly when these reach den
	assign rem0  = {{(esewh_pkg::DEN_W - HI_W){1'b0}}, num[esewh_pkg::NUM_W-1:esewh_pkg::MAG_W]};
	assign trial = {rem_q, sh_q[esewh_pkg::MAG_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};
	assign last  = sat_q || (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= esewh_pkg::STEP_W'(esewh_pkg::DIV_STEPS);
		end else if (busy_q) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= rem0;
			sh_q  <= num[esewh_pkg::MAG_W-1:0];
			quo_q <= '0;
			sat_q <= rem0 >= den;
		end else if (busy_q && !last) begin
			rem_q <= ge ? diff[esewh_pkg::DEN_W-1:0] : trial[esewh_pkg::DEN_W-1:0];
			sh_q  <= {sh_q[esewh_pkg::MAG_W-2:0], 1'b0};
			quo_q <= {quo_q[esewh_pkg::MAG_W-2:0], ge};
		end
	end

	assign rsp.done = busy_q && last;
	assign rsp.quo  = sat_q ? {esewh_pkg::MAG_W{1'b1}} : quo_q;

endmodule

// ===== src/encoder_speed_estimator_with_hold.sv =====
// Encoder speed estimator with hold: top level, sequencer and state.
// Depends on esewh_pkg, esewh_mul, esewh_div.
//
// Each input transaction carries an absolute encoder count and a microsecond
// timestamp; the block forms the deltas against the previous sample and the
// wheel speed in Q8 mm/s, holds the last speed above the zero threshold for
// hold_limit - 1 near-zero samples, and emits the reported speed in 0.001 km/h
// when its magnitude is below max_speed_mmps (else no output transaction).
// Between one accepted input transaction and the next, each item makes four
// passes through one shared 32x32 multiplier, runs a 31-step restoring
// divider, and makes a final multiply for the km/h scaling. The divider
// is skipped when counts_per_rev or the time delta is zero, and it ends without
// stepping when the quotient saturates. s_axis_tready is high only while the
// sequencer is idle. The result sits in an output register, so the next item
// is taken while it waits; the last step of that next item stalls as long as
// the output register still holds an unaccepted result.
// Configuration writes are to be made only while idle; the block does not enforce it.
module encoder_speed_estimator_with_hold (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [63:0]                          s_axis_tdata,  // encoder_count, timestamp_us
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [23:0]                          m_axis_tdata,  // speed_milli_kmh, zero pad
	output logic                                 m_axis_tuser,  // held
	input  logic                                 cfg_we,
	input  logic [esewh_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [esewh_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MDEN  = 9'b000000010,
		ST_MNUM  = 9'b000000100,
		ST_MPLO  = 9'b000001000,
		ST_MPHI  = 9'b000010000,
		ST_MSUM  = 9'b000100000,
		ST_DIV   = 9'b001000000,
		ST_POST  = 9'b010000000,
		ST_SCALE = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration
	logic [esewh_pkg::RADIUS_W-1:0] radius_q;
	logic [esewh_pkg::CPR_W-1:0]    cpr_q;
	logic [esewh_pkg::THR_W-1:0]    thr_q;
	logic [esewh_pkg::HOLD_W-1:0]   hold_q;
	logic [esewh_pkg::MAXSP_W-1:0]  maxsp_q;

	// persistent state
	logic [esewh_pkg::CNT_W-1:0]    prev_count_q;
	logic [esewh_pkg::TS_W-1:0]     prev_time_q;
	logic                           lnz_neg_q;
	logic [esewh_pkg::MAG_W-1:0]    lnz_mag_q;
	logic [esewh_pkg::HOLD_W-1:0]   zrun_q;

	// per-item working registers
	logic [esewh_pkg::CNT_W-1:0]    dmag_q;
	logic                           neg_q;
	logic [esewh_pkg::TS_W-1:0]     dt_q;
	logic [esewh_pkg::DEN_W-1:0]    den_q;
	logic [esewh_pkg::ANUM_W-32-1:0] ahi_q;
	logic [esewh_pkg::PROD_W-1:0]   plo_q;
	logic [esewh_pkg::MAG_W-1:0]    mag_q;
	logic                           rep_neg_q;
	logic                           held_q;
	logic [20:0]                    scl_q;

	// output register
	logic                           m_valid_q;
	logic [esewh_pkg::SPEED_W-1:0]  m_speed_q;
	logic                           m_held_q;

	// shared units
	logic [esewh_pkg::MUL_W-1:0]    mul_a;
	logic [esewh_pkg::MUL_W-1:0]    mul_b;
	logic [esewh_pkg::PROD_W-1:0]   mul_p;
	logic                           div_start;
	logic [esewh_pkg::NUM_W-1:0]    num;
	esewh_pkg::div_rsp_t            div_rsp;

	// combinational helpers
	logic                           in_acc;
	logic [esewh_pkg::CNT_W-1:0]    dc;
	logic [esewh_pkg::MAG_W-1:0]    zero_speed_gt;
	logic                           over_thr;
	logic [esewh_pkg::HOLD_W-1:0]   zrun_next;
	logic                           lnz_neg_next;
	logic [esewh_pkg::MAG_W-1:0]    lnz_mag_next;
	logic                           use_held;
	logic                           rep_neg;
	logic [esewh_pkg::MAG_W-1:0]    rmag;
	logic                           emit;
	logic [27:0]                    scaled;
	logic [20:0]                    quo5;
	logic [15:0]                    out_mag;
	logic                           out_load;

	esewh_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	esewh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den_q),
		.rsp    (div_rsp)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign dc            = s_axis_tdata[31:0] - prev_count_q;

	// a*K split in two 32-bit halves: low product plus high product << 32
	assign num = {{(esewh_pkg::NUM_W - esewh_pkg::PROD_W){1'b0}}, plo_q}
		+ {mul_p[esewh_pkg::NUM_W-33:0], 32'b0};
	assign div_start = (state_q == ST_MSUM) && (den_q != '0);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MDEN: begin
				mul_a = {16'b0, cpr_q};
				mul_b = dt_q;
			end
			ST_MNUM: begin
				mul_a = dmag_q;
				mul_b = {21'b0, radius_q};
			end
			ST_MPLO: begin
				mul_a = mul_p[31:0];
				mul_b = {1'b0, esewh_pkg::SPEED_K};
			end
			ST_MPHI: begin
				mul_a = {22'b0, ahi_q};
				mul_b = {1'b0, esewh_pkg::SPEED_K};
			end
			ST_POST: begin
				mul_a = {11'b0, scaled[27:7]};
				mul_b = {11'b0, esewh_pkg::DIV5_M};
			end
			// same operand again, so the product holds while the result waits
			ST_SCALE: begin
				mul_a = {11'b0, scl_q};
				mul_b = {11'b0, esewh_pkg::DIV5_M};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// hold logic on the finished magnitude
	assign zero_speed_gt = {7'b0, thr_q, 8'b0};
	assign over_thr      = mag_q > zero_speed_gt;
	assign zrun_next     = over_thr ? '0 : ((zrun_q == '1) ? zrun_q : zrun_q + 1'b1);
	assign lnz_neg_next  = over_thr ? neg_q : lnz_neg_q;
	assign lnz_mag_next  = over_thr ? mag_q : lnz_mag_q;
	assign use_held      = zrun_next < hold_q;
	assign rep_neg       = use_held ? lnz_neg_next : neg_q;
	assign rmag          = use_held ? lnz_mag_next : mag_q;
	assign emit          = rmag < {7'b0, maxsp_q, 8'b0};
	// rmag*9 + 320; only used when rmag < 2^24
	assign scaled = {1'b0, rmag[23:0], 3'b0} + {4'b0, rmag[23:0]} + esewh_pkg::ROUND_HALF;

	assign quo5     = mul_p[esewh_pkg::DIV5_SHIFT+20:esewh_pkg::DIV5_SHIFT];
	assign out_mag  = (quo5[20:16] != '0) ? esewh_pkg::OUT_MAX : quo5[15:0];
	assign out_load = (state_q == ST_SCALE) && (!m_valid_q || m_axis_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:  if (in_acc) state_q <= ST_MDEN;
				ST_MDEN:  state_q <= ST_MNUM;
				ST_MNUM:  state_q <= ST_MPLO;
				ST_MPLO:  state_q <= ST_MPHI;
				ST_MPHI:  state_q <= ST_MSUM;
				ST_MSUM:  state_q <= (den_q == '0) ? ST_POST : ST_DIV;
				ST_DIV:   if (div_rsp.done) state_q <= ST_POST;
				ST_POST:  state_q <= emit ? ST_SCALE : ST_IDLE;
				ST_SCALE: if (out_load) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// configuration and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q     <= esewh_pkg::RADIUS_RST;
			cpr_q        <= esewh_pkg::CPR_RST;
			thr_q        <= esewh_pkg::THR_RST;
			hold_q       <= esewh_pkg::HOLD_RST;
			maxsp_q      <= esewh_pkg::MAXSP_RST;
			prev_count_q <= '0;
			prev_time_q  <= '0;
			lnz_neg_q    <= 1'b0;
			lnz_mag_q    <= '0;
			zrun_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					esewh_pkg::REG_WHEEL_RADIUS: radius_q <= cfg_wdata[esewh_pkg::RADIUS_W-1:0];
					esewh_pkg::REG_COUNTS_REV:   cpr_q    <= cfg_wdata;
					esewh_pkg::REG_ZERO_THR:     thr_q    <= cfg_wdata;
					esewh_pkg::REG_HOLD_LIMIT:   hold_q   <= cfg_wdata[esewh_pkg::HOLD_W-1:0];
					esewh_pkg::REG_MAX_SPEED:    maxsp_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (in_acc) begin
				prev_count_q <= s_axis_tdata[31:0];
				prev_time_q  <= s_axis_tdata[63:32];
			end
			if (state_q == ST_POST) begin
				lnz_neg_q <= lnz_neg_next;
				lnz_mag_q <= lnz_mag_next;
				zrun_q    <= zrun_next;
			end
		end
	end

	// per-item datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			neg_q  <= dc[31];
			dmag_q <= dc[31] ? (32'd0 - dc) : dc;
			dt_q   <= s_axis_tdata[63:32] - prev_time_q;
		end
		case (state_q)
			ST_MNUM: den_q <= mul_p[esewh_pkg::DEN_W-1:0];
			ST_MPLO: ahi_q <= mul_p[esewh_pkg::ANUM_W-1:32];
			ST_MPHI: plo_q <= mul_p;
			ST_MSUM: mag_q <= '0;
			ST_DIV:  if (div_rsp.done) mag_q <= div_rsp.quo;
			ST_POST: begin
				rep_neg_q <= rep_neg;
				held_q    <= use_held && (zrun_next != '0);
				scl_q     <= scaled[27:7];
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_speed_q <= rep_neg_q ? (17'd0 - {1'b0, out_mag}) : {1'b0, out_mag};
			m_held_q  <= held_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'b0, m_speed_q};
	assign m_axis_tuser  = m_held_q;

endmodule
